>>> rtl/core/abbi_pkg.sv
// Package for the adaptive block bit inverter: widths, register indexes,
// configuration struct and the small helper functions used by the encoder.
// No dependencies.
package abbi_pkg;

  // Largest block in bits and the derived widths
  localparam int unsigned MaxBlock  = 64;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned CntW      = $clog2(MaxBlock + 1);
  localparam int unsigned PosW      = $clog2(MaxBlock);
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 7;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(4);

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE = 1'b0,
    CFG_METHOD     = 1'b1
  } abbi_cfg_idx_e;

  // Encoding methods
  typedef enum logic {
    METHOD_ADAPTIVE = 1'b0,
    METHOD_ROTATE   = 1'b1
  } abbi_method_e;

  // Live configuration seen by the encoder
  typedef struct packed {
    logic [SizeW-1:0] size;
    abbi_method_e     method;
  } abbi_cfg_t;

  // Clamp the block size register into 1..MaxBlock
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] raw_size);
    logic [SizeW-1:0] n;
    n = raw_size;
    if (n == '0) begin
      n = SizeW'(1);
    end else if (n > SizeW'(MaxBlock)) begin
      n = SizeW'(MaxBlock);
    end
    return n;
  endfunction

  // Ones in the low n bit positions
  function automatic logic [MaxBlock-1:0] low_mask(input logic [SizeW-1:0] n);
    logic [MaxBlock-1:0] m;
    for (int j = 0; j < MaxBlock; j++) begin
      m[j] = (SizeW'(j) < n);
    end
    return m;
  endfunction

  // Count the set bits of a block
  function automatic logic [CntW-1:0] ones_count(input logic [MaxBlock-1:0] x);
    logic [CntW-1:0] c;
    c = '0;
    for (int j = 0; j < MaxBlock; j++) begin
      c = c + CntW'(x[j]);
    end
    return c;
  endfunction

  // Residue of a block size modulo three, as a small lookup
  function automatic logic [1:0] size_mod3(input logic [SizeW-1:0] n);
    logic [1:0] r;
    r = '0;
    for (int k = 0; k <= MaxBlock; k++) begin
      if (n == SizeW'(k)) begin
        r = 2'(k % 3);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/core/abbi_in_stage.sv
// Input register of the adaptive block bit inverter: holds one accepted item
// until the encode stage takes it. Depends on abbi_pkg.
module abbi_in_stage import abbi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MaxBlock-1:0] block_bits_i,
  input  logic                start_of_line_i,
  input  logic                take_i,
  output logic                valid_o,
  output logic [MaxBlock-1:0] bits_o,
  output logic                start_o
);

  logic                valid_q, valid_d;
  logic [MaxBlock-1:0] bits_q;
  logic                start_q;
  logic                load;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload of a new item
  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q  <= block_bits_i;
      start_q <= start_of_line_i;
    end
  end

  assign valid_o = valid_q;
  assign bits_o  = bits_q;
  assign start_o = start_q;

endmodule

>>> rtl/core/abbi_encoder.sv
// Combinational block encoder: adaptive inversion against the previous raw
// block, or a one-bit rotate in stream order. Depends on abbi_pkg.
module abbi_encoder import abbi_pkg::*; (
  input  abbi_cfg_t           cfg_i,
  input  logic [MaxBlock-1:0] bits_i,
  input  logic                start_i,
  input  logic [MaxBlock-1:0] prev_i,
  output logic [MaxBlock-1:0] raw_o,
  output logic [MaxBlock-1:0] enc_o
);

  logic [SizeW-1:0]    n;
  logic [PosW-1:0]     top_pos;
  logic [MaxBlock-1:0] mask;
  logic [MaxBlock-1:0] raw;
  logic [CntW-1:0]     ones;
  logic [CntW:0]       ones_x2;
  logic [1:0]          n_mod3;
  logic [MaxBlock-1:0] every2;
  logic [MaxBlock-1:0] every3;
  logic [MaxBlock-1:0] rot;
  logic [MaxBlock-1:0] enc;

  assign n       = eff_size(cfg_i.size);
  assign top_pos = PosW'(n - SizeW'(1));
  assign mask    = low_mask(n);
  assign raw     = bits_i & mask;
  assign ones    = ones_count(prev_i & mask);
  assign ones_x2 = {ones, 1'b0};
  assign n_mod3  = size_mod3(n);

  // Stream position i sits at bit n-1-i: every p-th stream bit is a bit j
  // with j congruent to n modulo p
  always_comb begin
    for (int j = 0; j < MaxBlock; j++) begin
      every2[j] = (1'(j % 2) == n[0]);
      every3[j] = (2'(j % 3) == n_mod3);
    end
  end

  // Rotate right by one within the block
  assign rot = (raw >> 1) | (MaxBlock'(raw[0]) << top_pos);

  // Pick the transform
  always_comb begin
    if (cfg_i.method == METHOD_ROTATE) begin
      enc = rot;
    end else if (start_i) begin
      enc = ~raw;
    end else if (ones_x2 == (CntW + 1)'(n)) begin
      enc = ~raw;
    end else if (ones_x2 < (CntW + 1)'(n)) begin
      enc = raw ^ every2;
    end else begin
      enc = raw ^ every3;
    end
  end

  assign raw_o = raw;
  assign enc_o = enc & mask;

endmodule

>>> rtl/core/adaptive_block_bit_inverter_top.sv
// Top level of the adaptive block bit inverter: configuration registers,
// block history and result register. Depends on abbi_pkg, abbi_in_stage
// and abbi_encoder.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid_i, in_ready_o, block_bits_i,     | input
//            | start_of_line_i                           |
//   out      | out_valid_o, out_ready_i, encoded_bits_o  | output
//   cfg      | cfg_we_i, cfg_index_i, cfg_data_i         | input
//
// An item passes from acceptance into the input register, then through the
// encoder into the result register. One item per cycle is sustained while
// the output is taken; the encode step (popcount of the previous block and the
// invert mask) is the one logic stage. Reset clears the valid flags, the
// history block and the configuration (block size 4, method 0). A stalled
// output holds both registers; the input side keeps accepting while the input
// register is free.
module adaptive_block_bit_inverter_top import abbi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MaxBlock-1:0] block_bits_i,
  input  logic                start_of_line_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MaxBlock-1:0] encoded_bits_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  abbi_cfg_t           cfg_q;
  logic [MaxBlock-1:0] prev_q;
  logic                out_valid_q, out_valid_d;
  logic [MaxBlock-1:0] out_bits_q;

  logic                s1_valid;
  logic [MaxBlock-1:0] s1_bits;
  logic                s1_start;
  logic                advance;
  logic [MaxBlock-1:0] raw;
  logic [MaxBlock-1:0] enc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size   <= SizeReset;
      cfg_q.method <= METHOD_ADAPTIVE;
    end else if (cfg_we_i) begin
      unique case (abbi_cfg_idx_e'(cfg_index_i))
        CFG_BLOCK_SIZE: cfg_q.size   <= cfg_data_i[SizeW-1:0];
        CFG_METHOD:     cfg_q.method <= abbi_method_e'(cfg_data_i[0]);
        default:        cfg_q        <= cfg_q;
      endcase
    end
  end

  // Move an item to the result register when it is empty or being taken
  assign advance = s1_valid && (!out_valid_q || out_ready_i);

  abbi_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .block_bits_i    (block_bits_i),
    .start_of_line_i (start_of_line_i),
    .take_i          (advance),
    .valid_o         (s1_valid),
    .bits_o          (s1_bits),
    .start_o         (s1_start)
  );

  abbi_encoder u_encoder (
    .cfg_i   (cfg_q),
    .bits_i  (s1_bits),
    .start_i (s1_start),
    .prev_i  (prev_q),
    .raw_o   (raw),
    .enc_o   (enc)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Advance the history with the raw block of each encoded item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        prev_q <= raw;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_bits_q <= enc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign encoded_bits_o = out_bits_q;

endmodule
